// File: rtl/core/fkrs_pkg.sv
// fkrs_pkg: shared types and constants for the float key radix sorter
// no dependencies
package fkrs_pkg;

	localparam int unsigned KEY_W     = 32;
	localparam int unsigned DIGIT_W   = 8;
	localparam int unsigned BUCKETS   = 256;
	localparam int unsigned PASSES    = 4;
	localparam logic [KEY_W-1:0] SIGN_BIT = 32'h8000_0000;

	typedef enum logic [6:0] {
		ST_LOAD  = 7'b0000001,
		ST_CLEAR = 7'b0000010,
		ST_COUNT = 7'b0000100,
		ST_PREFX = 7'b0001000,
		ST_SCAT  = 7'b0010000,
		ST_EMIT  = 7'b0100000,
		ST_DRAIN = 7'b1000000
	} sort_state_t;

	function automatic logic [KEY_W-1:0] order_word(input logic [KEY_W-1:0] bits);
		order_word = bits[KEY_W-1] ? ~bits : (bits | SIGN_BIT);
	endfunction

	function automatic logic [DIGIT_W-1:0] key_digit(input logic [KEY_W-1:0] bits,
		input logic [1:0] pass);
		logic [KEY_W-1:0] w;
		w = order_word(bits) >> {pass, 3'b000};
		key_digit = w[DIGIT_W-1:0];
	endfunction

endpackage

// File: rtl/core/float_key_radix_sort.sv
// float_key_radix_sort: top level of the float key radix sorter
// depends on fkrs_pkg, fkrs_ram, fkrs_out_fifo
//
// Items are loaded one per cycle until one marked last arrives; full stays high
// from then until the sorted run has been emitted. Sorting takes four passes,
// each of a histogram clear, a count, a prefix scan and a scatter, the count
// and scatter reading one entry per cycle through the entry ram read port;
// then the entries are emitted one per cycle while the result queue holds
// fewer than two entries. Results go through a four-deep queue.
module float_key_radix_sort #(
	parameter int unsigned MAX_ENTRIES   = 64,
	parameter int unsigned PAYLOAD_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [fkrs_pkg::KEY_W-1:0] key_bits,
	input  logic [PAYLOAD_WIDTH-1:0]   payload,
	input  logic                       last_item,
	output logic                       empty,
	input  logic                       pop,
	output logic [fkrs_pkg::KEY_W-1:0] sorted_key_bits,
	output logic [PAYLOAD_WIDTH-1:0]   sorted_payload,
	output logic                       last_result,
	output logic                       overflowed,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_data
);
	import fkrs_pkg::*;

	localparam int unsigned AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned EW  = KEY_W + PAYLOAD_WIDTH;
	localparam int unsigned OW  = EW + 2;
	localparam int unsigned BAW = $clog2(BUCKETS);

	sort_state_t state_q;
	logic        desc_q;
	logic        ovf_q;
	logic [CW-1:0]  n_q;
	logic [CW-1:0]  idx_q;
	logic [1:0]     pass_q;
	logic           buf_q;
	logic [BAW:0]   bidx_q;
	logic [CW-1:0]  total_q;
	logic           rd_v_s1;
	logic [AW-1:0]  rd_i_s1;

	// bucket counter memory: read then write back, one read and one write per cycle
	logic           bk_we;
	logic [BAW-1:0] bk_wa;
	logic [CW-1:0]  bk_wd;
	logic [BAW-1:0] bk_ra;
	logic [CW-1:0]  bk_rd;

	logic          a_we, b_we;
	logic [AW-1:0] a_wa, b_wa, ram_ra;
	logic [EW-1:0] a_wd, b_wd, a_rd, b_rd, src_rd;

	logic [1:0]    fifo_lvl;
	logic          fifo_wr;
	logic [OW-1:0] fifo_wd, fifo_rdata;
	logic          fifo_ne;

	logic           accept;
	logic [BAW-1:0] dig_s1;
	logic           pipe_busy;

	fkrs_ram #(.WIDTH(EW), .DEPTH(1 << AW)) u_ram_a (
		.clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(ram_ra), .rdata(a_rd)
	);
	fkrs_ram #(.WIDTH(EW), .DEPTH(1 << AW)) u_ram_b (
		.clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(ram_ra), .rdata(b_rd)
	);
	fkrs_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_bucket (
		.clk(clk), .we(bk_we), .waddr(bk_wa), .wdata(bk_wd), .raddr(bk_ra), .rdata(bk_rd)
	);
	fkrs_out_fifo #(.WIDTH(OW)) u_fifo (
		.clk(clk), .arst_n(arst_n), .wr(fifo_wr), .wdata(fifo_wd), .level(fifo_lvl),
		.rd(pop && fifo_ne), .rdata(fifo_rdata), .nonempty(fifo_ne)
	);

	assign full      = state_q != ST_LOAD;
	assign accept    = push && !full;
	assign cfg_ready = 1'b1;
	assign empty     = !fifo_ne;
	assign sorted_key_bits = fifo_rdata[OW-1 -: KEY_W];
	assign sorted_payload  = fifo_rdata[PAYLOAD_WIDTH+1 : 2];
	assign last_result     = fifo_rdata[1];
	assign overflowed      = fifo_rdata[0];

	assign src_rd = buf_q ? b_rd : a_rd;
	assign dig_s1 = key_digit(src_rd[EW-1 -: KEY_W], pass_q);
	assign ram_ra = idx_q[AW-1:0];

	// counting and scattering read a bucket and write it back in the next cycle;
	// consecutive entries may hit the same bucket, so the last write is forwarded
	logic           fw_v_q;
	logic [BAW-1:0] fw_a_q;
	logic [CW-1:0]  fw_d_q;
	logic [BAW-1:0] bk_ra_q;
	logic [CW-1:0]  bk_val;
	logic [BAW-1:0] pre_b;

	assign bk_val = (fw_v_q && fw_a_q == bk_ra_q) ? fw_d_q : bk_rd;
	assign pre_b  = desc_q ? BAW'(BUCKETS - 1 - 32'(bidx_q[BAW-1:0]))
	                       : bidx_q[BAW-1:0];

	// pipeline for count/scatter: s1 has entry data, bucket read issued at s1
	logic           s2_v;
	logic [EW-1:0]  ent_s2;
	logic [BAW-1:0] dig_s2;
	logic           pre_v_s1;
	logic [BAW-1:0] pre_b_s1;

	always_comb begin
		bk_ra = bidx_q[BAW-1:0];
		case (state_q)
			ST_COUNT, ST_SCAT: bk_ra = dig_s1;
			ST_PREFX:          bk_ra = pre_b;
			default:           bk_ra = bidx_q[BAW-1:0];
		endcase
	end

	always_comb begin
		bk_we = 1'b0;
		bk_wa = fw_a_q;
		bk_wd = '0;
		case (state_q)
			ST_CLEAR: begin
				bk_we = 1'b1;
				bk_wa = bidx_q[BAW-1:0];
			end
			ST_COUNT, ST_SCAT: begin
				bk_we = s2_v;
				bk_wa = dig_s2;
				bk_wd = bk_val + CW'(1);
			end
			ST_PREFX: begin
				bk_we = pre_v_s1;
				bk_wa = pre_b_s1;
				bk_wd = total_q;
			end
			default: bk_we = 1'b0;
		endcase
	end

	logic [AW-1:0] scat_a;
	assign scat_a = bk_val[AW-1:0];

	always_comb begin
		a_we = 1'b0; a_wa = '0; a_wd = '0;
		b_we = 1'b0; b_wa = '0; b_wd = '0;
		if (state_q == ST_LOAD) begin
			a_we = accept && (n_q < CW'(MAX_ENTRIES));
			a_wa = n_q[AW-1:0];
			a_wd = {key_bits, payload};
		end else if (state_q == ST_SCAT && s2_v) begin
			if (buf_q) begin
				a_we = 1'b1; a_wa = scat_a; a_wd = ent_s2;
			end else begin
				b_we = 1'b1; b_wa = scat_a; b_wd = ent_s2;
			end
		end
	end

	assign fifo_wr = (state_q == ST_EMIT || state_q == ST_DRAIN) && rd_v_s1;
	assign fifo_wd = {src_rd, (32'(rd_i_s1) + 1 == 32'(n_q)), ovf_q};
	assign pipe_busy = rd_v_s1 || s2_v;

	always_ff @(posedge clk) begin
		ent_s2   <= src_rd;
		dig_s2   <= dig_s1;
		bk_ra_q  <= bk_ra;
		pre_b_s1 <= pre_b;
		fw_a_q   <= bk_wa;
		fw_d_q   <= bk_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			desc_q   <= 1'b0;
			ovf_q    <= 1'b0;
			n_q      <= '0;
			idx_q    <= '0;
			pass_q   <= '0;
			buf_q    <= 1'b0;
			bidx_q   <= '0;
			total_q  <= '0;
			rd_v_s1  <= 1'b0;
			rd_i_s1  <= '0;
			s2_v     <= 1'b0;
			pre_v_s1 <= 1'b0;
			fw_v_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				desc_q <= cfg_data;
			end
			fw_v_q   <= bk_we;
			rd_v_s1  <= 1'b0;
			s2_v     <= (state_q == ST_COUNT || state_q == ST_SCAT) && rd_v_s1;
			pre_v_s1 <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (n_q < CW'(MAX_ENTRIES)) begin
							n_q <= n_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_item) begin
							state_q <= ST_CLEAR;
							pass_q  <= '0;
							buf_q   <= 1'b0;
							bidx_q  <= '0;
						end
					end
				end
				ST_CLEAR: begin
					bidx_q <= bidx_q + (BAW+1)'(1);
					if (bidx_q[BAW-1:0] == BAW'(BUCKETS - 1)) begin
						state_q <= ST_COUNT;
						idx_q   <= '0;
					end
				end
				ST_COUNT, ST_SCAT: begin
					if (idx_q < n_q) begin
						rd_v_s1 <= 1'b1;
						idx_q   <= idx_q + CW'(1);
					end else if (!pipe_busy) begin
						idx_q  <= '0;
						bidx_q <= '0;
						if (state_q == ST_COUNT) begin
							state_q <= ST_PREFX;
							total_q <= '0;
						end else if (pass_q == 2'd3) begin
							state_q <= ST_EMIT;
							buf_q   <= 1'b0;
						end else begin
							state_q <= ST_CLEAR;
							pass_q  <= pass_q + 2'd1;
							buf_q   <= !buf_q;
						end
					end
				end
				ST_PREFX: begin
					if (!bidx_q[BAW]) begin
						bidx_q   <= bidx_q + (BAW+1)'(1);
						pre_v_s1 <= 1'b1;
					end
					if (pre_v_s1) begin
						total_q <= total_q + bk_rd;
					end
					if (bidx_q[BAW] && !pre_v_s1) begin
						state_q <= ST_SCAT;
						idx_q   <= '0;
					end
				end
				ST_EMIT: begin
					if (idx_q < n_q && fifo_lvl != 2'd2) begin
						rd_v_s1 <= 1'b1;
						rd_i_s1 <= idx_q[AW-1:0];
						idx_q   <= idx_q + CW'(1);
					end else if (idx_q >= n_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_v_s1) begin
						state_q <= ST_LOAD;
						n_q     <= '0;
						ovf_q   <= 1'b0;
						idx_q   <= '0;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

// File: rtl/core/fkrs_ram.sv
// fkrs_ram: generic single-write, single-read ram with registered read
// no dependencies
module fkrs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/core/fkrs_out_fifo.sv
// fkrs_out_fifo: small result queue between sort engine and result port
// no dependencies
module fkrs_out_fifo #(
	parameter int unsigned WIDTH = 66
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic [1:0]       level,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             nonempty
);
	logic [WIDTH-1:0] slot_q [4];
	logic [1:0]       wp_q;
	logic [1:0]       rp_q;
	logic [2:0]       cnt_q;

	assign rdata    = slot_q[rp_q];
	assign nonempty = cnt_q != 3'd0;
	assign level    = (cnt_q >= 3'd2) ? 2'd2 : cnt_q[1:0];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 2'd1;
			end
			if (rd) begin
				rp_q <= rp_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'b00, wr} - {2'b00, rd};
		end
	end
endmodule
